// ===== hw/rtl/dtpp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtpp_pkg
// Shared types and constants for the disparity to posed point pipeline.
// ----------------------------------------------------------------------------
package dtpp_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_PRINCIPAL_X    = 3'd0;
  localparam logic [2:0] CFG_PRINCIPAL_Y    = 3'd1;
  localparam logic [2:0] CFG_STEREO_BASELINE = 3'd2;
  localparam logic [2:0] CFG_BASELINE_FOCAL = 3'd3;
  localparam logic [2:0] CFG_POSE_ROW0      = 3'd4;
  localparam logic [2:0] CFG_POSE_ROW1      = 3'd5;
  localparam logic [2:0] CFG_POSE_ROW2      = 3'd6;
  localparam logic [2:0] CFG_POSE_ROW3      = 3'd7;

  // saturation limits of a Q15.16 result
  localparam logic [31:0] Q16_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q16_MIN = 32'h8000_0000;

  // quotient bits of the camera-point and the pose dividers
  localparam int unsigned CAM_QW  = 40;
  localparam int unsigned POSE_QW = 31;

  // sideband that rides along the camera-point divider
  typedef struct packed {
    logic       bad;
    logic       neg_x;
    logic       neg_y;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } cam_side_t;

  // sideband that rides along the pose divider
  typedef struct packed {
    logic       bad;
    logic       w_zero;
    logic [2:0] neg;
    logic [2:0] sat;
    logic [2:0] n_neg;
    logic [2:0] n_zero;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pose_side_t;

endpackage

// ===== hw/rtl/dtpp_div_pipe.sv =====
// ----------------------------------------------------------------------------
// dtpp_div_pipe
// Pipelined restoring divider: one quotient bit per stage, QW stages.
// The quotient must fit in QW bits; otherwise the result is undefined.
// ----------------------------------------------------------------------------
module dtpp_div_pipe #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 16,
  parameter int unsigned QW = 40
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int unsigned EW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [EW-1:0] shf;
    logic [EW-1:0] rem_ext;
    logic          fit;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    // trial subtract of the divisor aligned to this quotient bit
    assign shf     = EW'(den_in) << (QW - 1 - i);
    assign rem_ext = EW'(rem_in);
    assign fit     = rem_ext >= shf;

    always_ff @(posedge clk) begin
      rem_r[i] <= fit ? NW'(rem_ext - shf) : rem_in;
      den_r[i] <= den_in;
      quo_r[i] <= (quo_in << 1) | QW'(fit);
    end
  end

  assign quo = quo_r[QW-1];

endmodule

// ===== hw/rtl/disparity_to_posed_point_unit.sv =====
// ----------------------------------------------------------------------------
// disparity_to_posed_point_unit
// Reprojects a stereo disparity pixel to a 3-D point and applies a 4x4 pose.
// ----------------------------------------------------------------------------
//  channel  ports                                 handshake
//  input    in_pixel_col/row, in_disparity, rgb   start, busy (always low)
//  result   out_point_*, out_*_out                out_strobe, one cycle
//  config   cfg_index, cfg_data                   cfg_we, no wait
//
// One item enters every cycle; each result passes through the 40-stage
// camera-point divider and the 31-stage pose divider, one quotient bit per
// stage, plus eight plain register stages.
// Reset clears the configuration registers and the valid bits of the pipeline.
// The receiver cannot stall, so the pipe never holds.
module disparity_to_posed_point_unit
  import dtpp_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] in_pixel_col,
  input  logic [11:0] in_pixel_row,
  input  logic [15:0] in_disparity,
  input  logic [7:0]  in_blue_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_red_in,
  output logic        out_strobe,
  output logic        out_point_valid,
  output logic [31:0] out_point_x,
  output logic [31:0] out_point_y,
  output logic [31:0] out_point_z,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int unsigned CB        = (COORD_BITS < 12) ? COORD_BITS : 12;
  localparam logic [11:0] CMASK     = 12'((32'd1 << CB) - 32'd1);
  localparam int unsigned TOTAL_LAT = CAM_QW + POSE_QW + 8;

  // configuration registers
  logic [15:0] principal_x_r;
  logic [15:0] principal_y_r;
  logic [19:0] stereo_baseline_r;
  logic [31:0] baseline_focal_r;
  logic [63:0] pose_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      principal_x_r     <= '0;
      principal_y_r     <= '0;
      stereo_baseline_r <= '0;
      baseline_focal_r  <= '0;
      for (int i = 0; i < 4; i++) pose_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRINCIPAL_X:     principal_x_r     <= cfg_data[15:0];
        CFG_PRINCIPAL_Y:     principal_y_r     <= cfg_data[15:0];
        CFG_STEREO_BASELINE: stereo_baseline_r <= cfg_data[19:0];
        CFG_BASELINE_FOCAL:  baseline_focal_r  <= cfg_data[31:0];
        CFG_POSE_ROW0:       pose_r[0]         <= cfg_data;
        CFG_POSE_ROW1:       pose_r[1]         <= cfg_data;
        CFG_POSE_ROW2:       pose_r[2]         <= cfg_data;
        CFG_POSE_ROW3:       pose_r[3]         <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: capture the item
  logic        v1_r;
  logic [11:0] col1_r, row1_r;
  logic [15:0] dr1_r;
  logic [7:0]  b1_r, g1_r, r1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    col1_r <= in_pixel_col & CMASK;
    row1_r <= in_pixel_row & CMASK;
    dr1_r  <= in_disparity;
    b1_r   <= in_blue_in;
    g1_r   <= in_green_in;
    r1_r   <= in_red_in;
  end

  // stage 2: depth range check and offsets from the principal point
  logic        v2_r, bad2_r, negx2_r, negy2_r;
  logic [15:0] magx2_r, magy2_r, dr2_r;
  logic [47:0] numz2_r;
  logic [7:0]  b2_r, g2_r, r2_r;
  logic [21:0] dr60;
  logic [35:0] bf10;
  logic [16:0] dx, dy;

  always_comb begin
    dr60 = 22'(dr1_r) * 22'd60;
    bf10 = 36'(baseline_focal_r) * 36'd10;
    dx   = {1'b0, col1_r, 4'b0} - {1'b0, principal_x_r};
    dy   = {1'b0, row1_r, 4'b0} - {1'b0, principal_y_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    bad2_r  <= (dr1_r == 16'd0) || (baseline_focal_r >= 32'(dr60)) ||
               (bf10 <= 36'(dr1_r));
    negx2_r <= dx[16];
    negy2_r <= dy[16];
    magx2_r <= dx[16] ? 16'(-dx) : dx[15:0];
    magy2_r <= dy[16] ? 16'(-dy) : dy[15:0];
    numz2_r <= {baseline_focal_r, 16'b0};
    dr2_r   <= dr1_r;
    b2_r    <= b1_r;
    g2_r    <= g1_r;
    r2_r    <= r1_r;
  end

  // stage 3: lateral numerators, offset times baseline
  logic        v3_r;
  logic [39:0] numx3_r, numy3_r;
  logic [47:0] numz3_r;
  logic [15:0] dr3_r;
  cam_side_t   side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    numx3_r <= {36'(magx2_r) * 36'(stereo_baseline_r), 4'b0};
    numy3_r <= {36'(magy2_r) * 36'(stereo_baseline_r), 4'b0};
    numz3_r <= numz2_r;
    dr3_r   <= dr2_r;
    side3_r <= '{bad: bad2_r, neg_x: negx2_r, neg_y: negy2_r,
                 blue: b2_r, green: g2_r, red: r2_r};
  end

  // camera-point dividers
  logic [CAM_QW-1:0] qx, qy, qz;

  dtpp_div_pipe #(.NW(40), .DW(16), .QW(CAM_QW)) u_div_x (
    .clk(clk), .num(numx3_r), .den(dr3_r), .quo(qx)
  );
  dtpp_div_pipe #(.NW(40), .DW(16), .QW(CAM_QW)) u_div_y (
    .clk(clk), .num(numy3_r), .den(dr3_r), .quo(qy)
  );
  dtpp_div_pipe #(.NW(48), .DW(16), .QW(CAM_QW)) u_div_z (
    .clk(clk), .num(numz3_r), .den(dr3_r), .quo(qz)
  );

  // sideband delay matching the camera-point dividers
  logic      cam_vld_r  [CAM_QW];
  cam_side_t cam_side_r [CAM_QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CAM_QW; i++) cam_vld_r[i] <= 1'b0;
    end else begin
      cam_vld_r[0] <= v3_r;
      for (int i = 1; i < CAM_QW; i++) cam_vld_r[i] <= cam_vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    cam_side_r[0] <= side3_r;
    for (int i = 1; i < CAM_QW; i++) cam_side_r[i] <= cam_side_r[i-1];
  end

  // stage 4: signed camera point in Q16 metres
  logic               v4_r;
  logic signed [40:0] cam4_r [3];
  cam_side_t          side4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= cam_vld_r[CAM_QW-1];
  end

  always_ff @(posedge clk) begin
    cam4_r[0] <= cam_side_r[CAM_QW-1].neg_x ? -$signed(41'(qx)) : $signed(41'(qx));
    cam4_r[1] <= cam_side_r[CAM_QW-1].neg_y ? -$signed(41'(qy)) : $signed(41'(qy));
    cam4_r[2] <= $signed(41'(qz));
    side4_r   <= cam_side_r[CAM_QW-1];
  end

  // stage 5: pose products, kept exactly in Q30
  logic               v5_r;
  logic signed [56:0] prod5_r  [4][3];
  logic signed [58:0] trans5_r [4];
  cam_side_t          side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod5_r[r][c] <= 57'($signed(pose_r[r][16*c +: 16])) * 57'(cam4_r[c]);
      end
      trans5_r[r] <= 59'($signed(pose_r[r][63:48])) <<< 22;
    end
    side5_r <= side4_r;
  end

  // stage 6: row sums; row 3 is the divisor w
  logic               v6_r;
  logic signed [58:0] sum6_r [4];
  cam_side_t          side6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else        v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      sum6_r[r] <= 59'(prod5_r[r][0]) + 59'(prod5_r[r][1]) + 59'(prod5_r[r][2]) +
                   trans5_r[r];
    end
    side6_r <= side5_r;
  end

  // stage 7: magnitudes and signs ahead of the pose divide
  logic        v7_r;
  logic [57:0] an7_r [3];
  logic [57:0] aw7_r;
  logic [2:0]  neg7_r, nneg7_r, nzero7_r;
  logic        wzero7_r;
  cam_side_t   side7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else        v7_r <= v6_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      an7_r[k]    <= sum6_r[k][58] ? 58'(-sum6_r[k]) : 58'(sum6_r[k]);
      neg7_r[k]   <= sum6_r[k][58] ^ sum6_r[3][58];
      nneg7_r[k]  <= sum6_r[k][58];
      nzero7_r[k] <= sum6_r[k] == '0;
    end
    aw7_r    <= sum6_r[3][58] ? 58'(-sum6_r[3]) : 58'(sum6_r[3]);
    wzero7_r <= sum6_r[3] == '0;
    side7_r  <= side6_r;
  end

  // pose dividers, Q16 quotient of the numerator over w
  logic [POSE_QW-1:0] qp [3];
  logic [2:0]         sat7;

  for (genvar k = 0; k < 3; k++) begin : g_pose_div
    dtpp_div_pipe #(.NW(74), .DW(58), .QW(POSE_QW)) u_div (
      .clk(clk), .num({an7_r[k], 16'b0}), .den(aw7_r), .quo(qp[k])
    );
    // quotient of 2^15 or more saturates
    assign sat7[k] = 73'(an7_r[k]) >= {aw7_r, 15'b0};
  end

  // sideband delay matching the pose dividers
  logic       pose_vld_r  [POSE_QW];
  pose_side_t pose_side_r [POSE_QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POSE_QW; i++) pose_vld_r[i] <= 1'b0;
    end else begin
      pose_vld_r[0] <= v7_r;
      for (int i = 1; i < POSE_QW; i++) pose_vld_r[i] <= pose_vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    pose_side_r[0] <= '{bad: side7_r.bad, w_zero: wzero7_r, neg: neg7_r, sat: sat7,
                        n_neg: nneg7_r, n_zero: nzero7_r, blue: side7_r.blue,
                        green: side7_r.green, red: side7_r.red};
    for (int i = 1; i < POSE_QW; i++) pose_side_r[i] <= pose_side_r[i-1];
  end

  // final stage: sign, saturation, invalid pixels cleared
  pose_side_t  fin;
  logic [31:0] res_nxt [3];
  logic        strobe_r, valid_r;
  logic [31:0] res_r [3];
  logic [7:0]  red_r, green_r, blue_r;

  always_comb begin
    fin = pose_side_r[POSE_QW-1];
    for (int k = 0; k < 3; k++) begin
      if (fin.bad) begin
        res_nxt[k] = '0;
      end else if (fin.w_zero) begin
        res_nxt[k] = fin.n_zero[k] ? 32'd0 : (fin.n_neg[k] ? Q16_MIN : Q16_MAX);
      end else if (fin.sat[k]) begin
        res_nxt[k] = fin.neg[k] ? Q16_MIN : Q16_MAX;
      end else begin
        res_nxt[k] = fin.neg[k] ? 32'(-32'(qp[k])) : 32'(qp[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else        strobe_r <= pose_vld_r[POSE_QW-1];
  end

  always_ff @(posedge clk) begin
    valid_r <= !fin.bad;
    for (int k = 0; k < 3; k++) res_r[k] <= res_nxt[k];
    red_r   <= fin.bad ? 8'd0 : fin.red;
    green_r <= fin.bad ? 8'd0 : fin.green;
    blue_r  <= fin.bad ? 8'd0 : fin.blue;
  end

  assign out_strobe      = strobe_r;
  assign out_point_valid = valid_r;
  assign out_point_x     = res_r[0];
  assign out_point_y     = res_r[1];
  assign out_point_z     = res_r[2];
  assign out_red_out     = red_r;
  assign out_green_out   = green_r;
  assign out_blue_out    = blue_r;

  // every accepted item comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##TOTAL_LAT out_strobe)
    else $error("result strobe missing after item accept");

  // an invalid point carries no coordinates or color
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_point_valid |-> out_point_x == 32'd0 &&
      out_point_y == 32'd0 && out_point_z == 32'd0 && out_red_out == 8'd0 &&
      out_green_out == 8'd0 && out_blue_out == 8'd0)
    else $error("invalid point with nonzero fields");

  // zero disparity always gives an invalid point
  a_zero_disp: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_disparity == 16'd0 |->
      ##TOTAL_LAT (out_strobe && !out_point_valid))
    else $error("zero disparity reported as valid");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the disparity to posed point unit against a bit-exact predictor:
// a directed table of pixels, then random pixels over several register
// settings, with random sender gaps and a final phase sent without gaps.
// ----------------------------------------------------------------------------
module testbench
  import dtpp_pkg::*;
;

  typedef struct {
    logic        valid;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } point_t;

  typedef struct {
    logic [11:0] col;
    logic [11:0] row;
    logic [15:0] disp;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [31:0] bf;
    bit          typed_zero;
  } pixel_row_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int N_PHASES       = 8;
  localparam int PHASE_ITEMS    = 142;
  localparam int QUIET_ITEMS    = 150;
  localparam logic [63:0] UNIT_W_ROW = {16'sd256, 16'd0, 16'd0, 16'd0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [11:0] in_pixel_col = '0;
  logic [11:0] in_pixel_row = '0;
  logic [15:0] in_disparity = '0;
  logic [7:0]  in_blue_in = '0;
  logic [7:0]  in_green_in = '0;
  logic [7:0]  in_red_in = '0;
  logic        out_strobe;
  logic        out_point_valid;
  logic [31:0] out_point_x;
  logic [31:0] out_point_y;
  logic [31:0] out_point_z;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        typed_zero = 1'b0;

  // register copy used for prediction
  logic [15:0] m_cu;
  logic [15:0] m_cv;
  logic [19:0] m_base;
  logic [31:0] m_bf;
  logic [63:0] m_pose [4];

  point_t point_q [$];
  int     errors = 0;
  int     quiet_cnt = 0;
  bit     no_idle = 0;

  disparity_to_posed_point_unit dut (.*);

  always #1 clk = ~clk;

  // append one expected point at the tail
  function automatic void queue_point(point_t p);
    point_q.insert(point_q.size(), p);
  endfunction

  function automatic longint sx16(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint pose_dot(logic [63:0] r, longint x, longint y, longint z);
    return sx16(r[15:0]) * x + sx16(r[31:16]) * y + sx16(r[47:32]) * z
         + sx16(r[63:48]) * 64'sd4194304;
  endfunction

  function automatic longint lateral(longint delta4, longint unsigned dr);
    longint unsigned mag;
    longint unsigned v;
    mag = (delta4 < 0) ? longint'(-delta4) : longint'(delta4);
    v = (mag * longint'(m_base) * 16) / dr;
    return (delta4 < 0) ? -longint'(v) : longint'(v);
  endfunction

  // truncated Q16 quotient with saturation
  function automatic logic [31:0] quot_q16(longint n, longint d);
    bit neg;
    longint unsigned an, ad, q, r;
    if (d == 0) begin
      if (n > 0) return Q16_MAX;
      if (n < 0) return Q16_MIN;
      return '0;
    end
    neg = (n < 0) != (d < 0);
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = an / ad;
    if (q >= 32768) return neg ? Q16_MIN : Q16_MAX;
    r = an % ad;
    for (int i = 0; i < 16; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= ad) begin
        r = r - ad;
        q = q | 1;
      end
    end
    return neg ? 32'(-longint'(q)) : 32'(q);
  endfunction

  function automatic point_t project_pixel(logic [11:0] col, logic [11:0] row,
                                           logic [15:0] disp, logic [7:0] b,
                                           logic [7:0] g, logic [7:0] r);
    point_t p;
    longint unsigned dr, bf;
    longint cx, cy, cz, w;
    p = '{1'b0, '0, '0, '0, '0, '0, '0};
    dr = disp;
    bf = m_bf;
    if (dr == 0 || bf >= 60 * dr || 10 * bf <= dr) return p;
    cz = longint'((bf << 16) / dr);
    cx = lateral(longint'(col) * 16 - longint'(m_cu), dr);
    cy = lateral(longint'(row) * 16 - longint'(m_cv), dr);
    w = pose_dot(m_pose[3], cx, cy, cz);
    p.valid = 1'b1;
    p.px = quot_q16(pose_dot(m_pose[0], cx, cy, cz), w);
    p.py = quot_q16(pose_dot(m_pose[1], cx, cy, cz), w);
    p.pz = quot_q16(pose_dot(m_pose[2], cx, cy, cz), w);
    p.red = r;
    p.green = g;
    p.blue = b;
    return p;
  endfunction

  // input acceptance and result check
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      if (typed_zero)
        queue_point('{1'b0, '0, '0, '0, '0, '0, '0});
      else
        queue_point(project_pixel(in_pixel_col, in_pixel_row, in_disparity,
                                  in_blue_in, in_green_in, in_red_in));
    end
    if (rst_n && out_strobe) begin
      if (point_q.size() == 0) begin
        $error("result with no item waiting");
        errors++;
      end else begin
        point_t e;
        e = point_q.pop_front();
        if (out_point_valid !== e.valid) begin
          $error("point_valid exp %0d got %0d", e.valid, out_point_valid); errors++;
        end
        if (out_point_x !== e.px) begin
          $error("point_x exp %h got %h", e.px, out_point_x); errors++;
        end
        if (out_point_y !== e.py) begin
          $error("point_y exp %h got %h", e.py, out_point_y); errors++;
        end
        if (out_point_z !== e.pz) begin
          $error("point_z exp %h got %h", e.pz, out_point_z); errors++;
        end
        if (out_red_out !== e.red) begin
          $error("red_out exp %h got %h", e.red, out_red_out); errors++;
        end
        if (out_green_out !== e.green) begin
          $error("green_out exp %h got %h", e.green, out_green_out); errors++;
        end
        if (out_blue_out !== e.blue) begin
          $error("blue_out exp %h got %h", e.blue, out_blue_out); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe)
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one register write, caller lowers cfg_we
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_PRINCIPAL_X:     m_cu = val[15:0];
      CFG_PRINCIPAL_Y:     m_cv = val[15:0];
      CFG_STEREO_BASELINE: m_base = val[19:0];
      CFG_BASELINE_FOCAL:  m_bf = val[31:0];
      default:             m_pose[2'(idx - CFG_POSE_ROW0)] = val;
    endcase
    @(posedge clk);
  endtask

  // let the pipe empty before touching registers
  task automatic wait_idle();
    start <= 1'b0;
    while (point_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [15:0] disp,
                            logic [7:0] b, logic [7:0] g, logic [7:0] r, bit tz);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    start <= 1'b1;
    in_pixel_col <= col;
    in_pixel_row <= row;
    in_disparity <= disp;
    in_blue_in <= b;
    in_green_in <= g;
    in_red_in <= r;
    typed_zero <= tz;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [15:0] rot_word(bit diag);
    int v;
    v = diag ? 16384 + $urandom_range(0, 1024) - 512 : $urandom_range(0, 2048) - 1024;
    return 16'(v);
  endfunction

  // pose row for a given phase style
  function automatic logic [63:0] pose_row(int style, int r);
    case (style)
      0: begin
        if (r == 3) return UNIT_W_ROW;
        return {16'($urandom), rot_word(r == 2), rot_word(r == 1), rot_word(r == 0)};
      end
      1: return {$urandom, $urandom};
      2: return '0;
      3: return (r % 2) ? {4{16'h8000}} : {4{16'h7fff}};
      default: begin
        if (r == 3) return {16'($urandom_range(1, 1024)), 16'($urandom_range(0, 64)),
                            16'($urandom_range(0, 64)), 16'($urandom_range(0, 64))};
        return {16'($urandom), rot_word(r == 2), rot_word(r == 1), rot_word(r == 0)};
      end
    endcase
  endfunction

  task automatic setup_phase(int p);
    logic [31:0] bf;
    int style;
    case (p)
      1:       bf = 32'hffff_ffff;
      2:       bf = 32'd1;
      default: bf = 256 * $urandom_range(20, 3000);
    endcase
    style = (p == 3) ? 2 : (p == 4) ? 3 : (p == 5) ? 1 : (p == 6) ? 4 : 0;
    write_reg(CFG_PRINCIPAL_X, (p == 1) ? 64'hffff : (p == 2) ? 64'h0 : 64'($urandom));
    write_reg(CFG_PRINCIPAL_Y, (p == 1) ? 64'h0 : (p == 2) ? 64'hffff : 64'($urandom));
    write_reg(CFG_STEREO_BASELINE, (p == 1) ? 64'hfffff : (p == 7) ? 64'h0 :
              64'($urandom_range(1, 20'hfffff)));
    write_reg(CFG_BASELINE_FOCAL, 64'(bf));
    for (int r = 0; r < 4; r++)
      write_reg(3'(CFG_POSE_ROW0 + r), pose_row(style, r));
    cfg_we <= 1'b0;
  endtask

  // random pixel, mostly with a disparity in the valid depth window
  task automatic random_pixel();
    longint lo, hi;
    logic [15:0] d;
    lo = longint'(m_bf) / 60 + 1;
    hi = 10 * longint'(m_bf) - 1;
    if (hi > 65535) hi = 65535;
    if (lo <= hi && $urandom_range(0, 9) < 8)
      d = 16'($urandom_range(int'(lo), int'(hi)));
    else
      d = 16'($urandom);
    send_pixel(12'($urandom), 12'($urandom), d, 8'($urandom), 8'($urandom),
               8'($urandom), 1'b0);
  endtask

  pixel_row_t pixel_table [] = '{
    // after reset: all registers zero, every pixel too near
    '{12'd0,    12'd0,    16'd256,   8'h11, 8'h22, 8'h33, 32'd0,      1'b1},
    '{12'hfff,  12'hfff,  16'hffff,  8'hff, 8'hff, 8'hff, 32'd0,      1'b1},
    // zero disparity
    '{12'd5,    12'd7,    16'd0,     8'haa, 8'h55, 8'h0f, 32'd128000, 1'b1},
    // too far, on the boundary and just inside
    '{12'd100,  12'd100,  16'd2133,  8'h01, 8'h02, 8'h03, 32'd128000, 1'b1},
    '{12'd100,  12'd100,  16'd2134,  8'h04, 8'h05, 8'h06, 32'd128000, 1'b0},
    '{12'd128,  12'd96,   16'd4096,  8'h10, 8'h20, 8'h30, 32'd128000, 1'b0},
    '{12'd0,    12'd0,    16'hffff,  8'h00, 8'h00, 8'h00, 32'd128000, 1'b0},
    '{12'hfff,  12'hfff,  16'd2200,  8'hff, 8'hff, 8'hff, 32'd128000, 1'b0},
    '{12'hfff,  12'd0,    16'd30000, 8'h80, 8'h7f, 8'h01, 32'd128000, 1'b0},
    '{12'd0,    12'hfff,  16'd12345, 8'hfe, 8'h01, 8'h80, 32'd128000, 1'b0},
    '{12'h555,  12'haaa,  16'h5555,  8'h55, 8'haa, 8'h5a, 32'd128000, 1'b0},
    '{12'haaa,  12'h555,  16'haaaa,  8'haa, 8'h55, 8'ha5, 32'd128000, 1'b0},
    // too near, on the boundary and just inside
    '{12'd50,   12'd60,   16'd1000,  8'h12, 8'h34, 8'h56, 32'd100,    1'b1},
    '{12'd50,   12'd60,   16'd999,   8'h65, 8'h43, 8'h21, 32'd100,    1'b0},
    '{12'd128,  12'd96,   16'd2,     8'h77, 8'h88, 8'h99, 32'd100,    1'b0},
    '{12'hfff,  12'hfff,  16'd1,     8'hff, 8'h00, 8'hff, 32'd100,    1'b0},
    '{12'd0,    12'd0,    16'hffff,  8'h00, 8'hff, 8'h00, 32'd100,    1'b1}
  };

  initial begin
    m_cu = '0; m_cv = '0; m_base = '0; m_bf = '0;
    for (int r = 0; r < 4; r++) m_pose[r] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; after the two reset rows, identity pose with unit divisor
    foreach (pixel_table[i]) begin
      if (i == 2) begin
        wait_idle();
        write_reg(CFG_PRINCIPAL_X, 64'h800);
        write_reg(CFG_PRINCIPAL_Y, 64'h600);
        write_reg(CFG_STEREO_BASELINE, 64'h10000);
        write_reg(CFG_BASELINE_FOCAL, 64'(pixel_table[i].bf));
        write_reg(CFG_POSE_ROW0, 64'd16384);
        write_reg(CFG_POSE_ROW1, 64'd16384 << 16);
        write_reg(CFG_POSE_ROW2, 64'd16384 << 32);
        write_reg(CFG_POSE_ROW3, UNIT_W_ROW);
        cfg_we <= 1'b0;
      end else if (i > 2 && pixel_table[i].bf != m_bf) begin
        wait_idle();
        write_reg(CFG_BASELINE_FOCAL, 64'(pixel_table[i].bf));
        cfg_we <= 1'b0;
      end
      send_pixel(pixel_table[i].col, pixel_table[i].row, pixel_table[i].disp,
                 pixel_table[i].blue, pixel_table[i].green, pixel_table[i].red,
                 pixel_table[i].typed_zero);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      setup_phase(p);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == N_PHASES - 1 && k >= PHASE_ITEMS - QUIET_ITEMS) no_idle = 1;
        random_pixel();
      end
    end

    start <= 1'b0;
    while (point_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dtpp_pkg.sv
hw/rtl/dtpp_div_pipe.sv
hw/rtl/disparity_to_posed_point_unit.sv
tb/testbench.sv
